>>> sv/vtpac_pkg.sv
// Shared constants and types for the vector-to-polar-angle cosine pipeline.
// No dependencies; imported by every module of the block.
package vtpac_pkg;

  localparam int IN_WIDTH  = 32;
  localparam int FRAC_BITS = 30;
  localparam int MAG_W     = 32;
  localparam int EXT_W     = IN_WIDTH + MAG_W;
  localparam int SH_W      = $clog2(IN_WIDTH + 1);
  localparam int SQ_W      = 2 * MAG_W;
  localparam int QB        = 2 * FRAC_BITS + 3;
  localparam int RB        = FRAC_BITS + 2;
  localparam int TW        = 2 * RB + 1;
  localparam int FRONT_LAT = 5;
  localparam int RR_LAT    = QB + RB + 1;
  localparam int TOTAL_LAT = FRONT_LAT + RR_LAT + 1;

  localparam logic [EXT_W-1:0] MAG_LIMIT = EXT_W'(1) << (MAG_W - 1);
  localparam logic [FRAC_BITS:0] ONE_FX = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  typedef struct packed {
    logic nx;
    logic ny;
    logic nz;
    logic zero;
    logic axis;
  } meta_t;

  typedef struct packed {
    logic [SQ_W-1:0] x2;
    logic [SQ_W-1:0] y2;
    logic [SQ_W-1:0] z2;
    logic [SQ_W-1:0] r2;
    logic [SQ_W-1:0] s2;
  } sq_t;

endpackage

>>> sv/vtpac_front.sv
// Front end: sign split, range shift, squares and sums of squares.
// Depends on vtpac_pkg.
module vtpac_front import vtpac_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic signed [IN_WIDTH-1:0] px_i,
  input  logic signed [IN_WIDTH-1:0] py_i,
  input  logic signed [IN_WIDTH-1:0] pz_i,
  output logic                       valid_o,
  output meta_t                      meta_o,
  output sq_t                        sq_o
);

  logic [FRONT_LAT-1:0] v_q;
  meta_t                m1_q, m2_q, m3_q, m4_q, m5_q;
  logic [IN_WIDTH-1:0]  ax_q, ay_q, az_q;
  logic [IN_WIDTH-1:0]  bx_q, by_q, bz_q, mx_q;
  logic [MAG_W-1:0]     cx_q, cy_q, cz_q;
  logic [SQ_W-1:0]      x2_q, y2_q, z2_q;
  sq_t                  sq_q;

  logic [IN_WIDTH-1:0]  ux, uy, uz, mxy;
  logic [SH_W-1:0]      sh;
  logic [MAG_W-1:0]     sx, sy, sz;
  meta_t                m1_d, m3_d;

  assign ux = $unsigned(px_i);
  assign uy = $unsigned(py_i);
  assign uz = $unsigned(pz_i);

  always_comb begin
    m1_d      = '0;
    m1_d.nx   = ux[IN_WIDTH-1];
    m1_d.ny   = uy[IN_WIDTH-1];
    m1_d.nz   = uz[IN_WIDTH-1];
    m1_d.zero = (ux == '0) && (uy == '0) && (uz == '0);
  end

  assign mxy = (ax_q > ay_q) ? ax_q : ay_q;

  always_comb begin
    sh = '0;
    for (int i = IN_WIDTH; i >= 0; i--) begin
      if ((EXT_W'(mx_q) >> i) <= MAG_LIMIT) sh = SH_W'(i);
    end
  end

  assign sx = MAG_W'(EXT_W'(bx_q) >> sh);
  assign sy = MAG_W'(EXT_W'(by_q) >> sh);
  assign sz = MAG_W'(EXT_W'(bz_q) >> sh);

  always_comb begin
    m3_d      = m2_q;
    m3_d.axis = (sx == '0) && (sy == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[FRONT_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q <= m1_d;
    ax_q <= m1_d.nx ? (IN_WIDTH)'(0) - ux : ux;
    ay_q <= m1_d.ny ? (IN_WIDTH)'(0) - uy : uy;
    az_q <= m1_d.nz ? (IN_WIDTH)'(0) - uz : uz;
    m2_q <= m1_q;
    bx_q <= ax_q;
    by_q <= ay_q;
    bz_q <= az_q;
    mx_q <= (mxy > az_q) ? mxy : az_q;
    m3_q <= m3_d;
    cx_q <= sx;
    cy_q <= sy;
    cz_q <= sz;
    m4_q <= m3_q;
    x2_q <= SQ_W'(cx_q) * SQ_W'(cx_q);
    y2_q <= SQ_W'(cy_q) * SQ_W'(cy_q);
    z2_q <= SQ_W'(cz_q) * SQ_W'(cz_q);
    m5_q <= m4_q;
    sq_q.x2 <= x2_q;
    sq_q.y2 <= y2_q;
    sq_q.z2 <= z2_q;
    sq_q.r2 <= x2_q + y2_q;
    sq_q.s2 <= x2_q + y2_q + z2_q;
  end

  // ax_q..az_q feed the max; bx_q..bz_q, aligned with mx_q, feed the shift
  assign valid_o = v_q[FRONT_LAT-1];
  assign meta_o  = m5_q;
  assign sq_o    = sq_q;

endmodule

>>> sv/vtpac_root_ratio.sv
// Pipelined round(sqrt(num/den) * 2^FRAC_BITS): one quotient bit per stage,
// then one root bit per stage, then rounding. Depends on vtpac_pkg.
module vtpac_root_ratio import vtpac_pkg::*; (
  input  logic              clk_i,
  input  logic [SQ_W-1:0]   num_i,
  input  logic [SQ_W-1:0]   den_i,
  output logic [FRAC_BITS:0] mag_o
);

  logic [SQ_W-1:0]  rem_q [QB];
  logic [SQ_W-1:0]  den_q [QB];
  logic [QB-1:0]    quo_q [QB];
  logic [TW-1:0]    rad_q [RB];
  logic [RB-1:0]    root_q [RB];
  logic [FRAC_BITS:0] mag_q;

  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [SQ_W:0]   t;
    logic [SQ_W-1:0] din;
    logic [QB-1:0]   qin;
    logic            ge;
    if (s == 0) begin : g_first
      assign t   = {1'b0, num_i};
      assign din = den_i;
      assign qin = '0;
    end else begin : g_next
      assign t   = {rem_q[s-1], 1'b0};
      assign din = den_q[s-1];
      assign qin = quo_q[s-1];
    end
    assign ge = t >= {1'b0, din};
    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? SQ_W'(t - {1'b0, din}) : t[SQ_W-1:0];
      den_q[s] <= din;
      quo_q[s] <= {qin[QB-2:0], ge};
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam int B = RB - 1 - j;
    logic [TW-1:0] rin, trial;
    logic [RB-1:0] qin;
    logic          ge;
    if (j == 0) begin : g_first
      assign rin = TW'(quo_q[QB-1]);
      assign qin = '0;
    end else begin : g_next
      assign rin = rad_q[j-1];
      assign qin = root_q[j-1];
    end
    assign trial = (TW'(qin) << (B + 1)) | (TW'(1) << (2 * B));
    assign ge    = trial <= rin;
    always_ff @(posedge clk_i) begin
      rad_q[j]  <= ge ? rin - trial : rin;
      root_q[j] <= qin | (RB'(ge) << B);
    end
  end

  logic [RB:0] rnd;
  assign rnd = ({1'b0, root_q[RB-1]} + (RB + 1)'(1)) >> 1;

  always_ff @(posedge clk_i) begin
    mag_q <= rnd[FRAC_BITS:0];
  end

  assign mag_o = mag_q;

endmodule

>>> sv/vector_to_polar_azimuth_cosines.sv
// Polar and azimuth cosines/sines of a 3-vector, fully pipelined.
// One transfer per cycle from start to done_o through the bit-per-stage
// divider (63 stages) and root (32 stages) pipes.
// busy is never raised; the receiver cannot stall and none is needed.
// Reset clears only the valid line; results in flight are dropped.
// Depends on vtpac_pkg, vtpac_front, vtpac_root_ratio.
module vector_to_polar_azimuth_cosines import vtpac_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [IN_WIDTH-1:0] px_i,
  input  logic signed [IN_WIDTH-1:0] py_i,
  input  logic signed [IN_WIDTH-1:0] pz_i,
  output logic                       done_o,
  output logic signed [31:0]         cos_theta_o,
  output logic        [30:0]         sin_theta_o,
  output logic signed [31:0]         cos_phi_o,
  output logic signed [31:0]         sin_phi_o,
  output logic                       rotate_o,
  output logic                       zero_vector_o
);

  logic        fv;
  meta_t       fmeta;
  sq_t         fsq;
  logic [FRAC_BITS:0] m_ct, m_st, m_cp, m_sp;

  logic [RR_LAT-1:0] vline_q;
  meta_t             mline_q [RR_LAT];
  meta_t             m;

  logic               done_q, rot_q, zero_q;
  logic signed [31:0] ct_q, cp_q, sp_q;
  logic [30:0]        st_q;

  assign busy = 1'b0;

  vtpac_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .px_i    (px_i),
    .py_i    (py_i),
    .pz_i    (pz_i),
    .valid_o (fv),
    .meta_o  (fmeta),
    .sq_o    (fsq)
  );

  vtpac_root_ratio u_ct (.clk_i(clk_i), .num_i(fsq.z2), .den_i(fsq.s2), .mag_o(m_ct));
  vtpac_root_ratio u_st (.clk_i(clk_i), .num_i(fsq.r2), .den_i(fsq.s2), .mag_o(m_st));
  vtpac_root_ratio u_cp (.clk_i(clk_i), .num_i(fsq.x2), .den_i(fsq.r2), .mag_o(m_cp));
  vtpac_root_ratio u_sp (.clk_i(clk_i), .num_i(fsq.y2), .den_i(fsq.r2), .mag_o(m_sp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vline_q <= '0;
      done_q  <= 1'b0;
    end else begin
      vline_q <= {vline_q[RR_LAT-2:0], fv};
      done_q  <= vline_q[RR_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    mline_q[0] <= fmeta;
    for (int i = 1; i < RR_LAT; i++) mline_q[i] <= mline_q[i-1];
  end

  function automatic logic signed [31:0] with_sign(logic [FRAC_BITS:0] mag, logic neg);
    logic [31:0] u;
    u = 32'(mag);
    return neg ? $signed(32'(0) - u) : $signed(u);
  endfunction

  assign m = mline_q[RR_LAT-1];

  always_ff @(posedge clk_i) begin
    if (m.zero) begin
      ct_q   <= with_sign(ONE_FX, 1'b0);
      st_q   <= '0;
      cp_q   <= with_sign(ONE_FX, 1'b0);
      sp_q   <= '0;
      rot_q  <= 1'b0;
      zero_q <= 1'b1;
    end else if (m.axis) begin
      ct_q   <= with_sign(ONE_FX, m.nz);
      st_q   <= '0;
      cp_q   <= with_sign(ONE_FX, 1'b0);
      sp_q   <= '0;
      rot_q  <= m.nz;
      zero_q <= 1'b0;
    end else begin
      ct_q   <= with_sign(m_ct, m.nz);
      st_q   <= 31'(m_st);
      cp_q   <= with_sign(m_cp, m.nx);
      sp_q   <= with_sign(m_sp, m.ny);
      rot_q  <= 1'b1;
      zero_q <= 1'b0;
    end
  end

  assign done_o        = done_q;
  assign cos_theta_o   = ct_q;
  assign sin_theta_o   = st_q;
  assign cos_phi_o     = cp_q;
  assign sin_phi_o     = sp_q;
  assign rotate_o      = rot_q;
  assign zero_vector_o = zero_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##TOTAL_LAT done_o)
    else $error("transfer did not complete at fixed latency");

  a_zero_norot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_vector_o) |-> (!rotate_o && cos_theta_o == 32'sd1073741824))
    else $error("zero vector result not defaulted");

  a_norot_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rotate_o) |-> (sin_theta_o == '0 && sin_phi_o == '0))
    else $error("unrotated result off axis");

  a_sin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sin_theta_o <= 31'd1073741824))
    else $error("sin_theta out of range");

endmodule
